### rtl/pti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polynomial trapezoid integrator package
// Shared constants, controller state codes, datapath command and status
// types, and the saturating arithmetic helpers.
// ----------------------------------------------------------------------------
package pti_pkg;

  localparam int MAX_DEGREE   = 4;
  localparam int MAX_SEGMENTS = 128;

  localparam int SEG_W     = 8;    // segment count field
  localparam int DEG_W     = 3;    // polynomial degree register
  localparam int K_W       = 3;    // coefficient index, 0 .. MAX_DEGREE + 1
  localparam int CFG_IDX_W = 3;    // configuration register index
  localparam int CFG_W     = 32;   // configuration data
  localparam int COEF_W    = 32;   // Q16.16 values
  localparam int VAL_W     = 64;   // Q32.32 values
  localparam int CNT_W     = 6;    // divider step counter
  localparam int DIV_W     = 48;   // divider magnitude
  localparam int Q_W       = 49;   // signed quotient (step and antiderivative terms)
  localparam int HACC_W    = 56;   // running step multiple
  localparam int OP_W      = 33;   // multiplier operand
  localparam int PP_W      = 66;   // multiplier product
  localparam int ACC_W     = 128;  // product accumulator

  localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_END    = 3'd7;

  localparam logic signed [COEF_W-1:0] RANGE_END_RST = 32'sh0001_0000;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    logic ovf;
    val_t val;
  } sat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_LOAD,
    S_DIV_STEP,
    S_DIV_SAVE,
    S_PT_LOAD,
    S_H_INIT,
    S_H_MUL0,
    S_H_MUL1,
    S_H_WAIT,
    S_H_FIN,
    S_H_DONE,
    S_A_MUL,
    S_A_WAIT,
    S_AREA,
    S_ERR,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    PH_FA,
    PH_FB,
    PH_INT,
    PH_ANTI_B,
    PH_ANTI_A
  } ph_t;

  typedef enum logic [1:0] {
    PT_START,
    PT_END,
    PT_NEXT
  } pt_sel_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_START,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_SAVE_H,
    OP_SAVE_AC,
    OP_PT_LOAD,
    OP_HORN_INIT,
    OP_MUL,
    OP_HORN_FIN,
    OP_SUM_F,
    OP_SUM_2F,
    OP_AREA,
    OP_FB_SAVE,
    OP_EXACT,
    OP_ERR,
    OP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [K_W-1:0]   k;
    logic             anti;
    pt_sel_t          pt;
    logic             div_h;
    logic [SEG_W-1:0] divisor;
    logic             mul_area;
    logic             a_hi;
    logic             b_hi;
    logic             mul_clr;
  } dp_cmd_t;

  typedef struct packed {
    logic [DEG_W-1:0] deg;
  } dp_sts_t;

  // Saturate a wide signed value to 64 bits.
  function automatic sat_t narrow_sat(input logic signed [ACC_W-1:0] v);
    sat_t r;
    if (v[ACC_W-1:VAL_W-1] == {(ACC_W-VAL_W+1){v[VAL_W-1]}}) begin
      r.ovf = 1'b0;
      r.val = v[VAL_W-1:0];
    end else begin
      r.ovf = 1'b1;
      r.val = v[ACC_W-1] ? VAL_MIN : VAL_MAX;
    end
    return r;
  endfunction

  function automatic sat_t from65(input logic signed [VAL_W:0] s);
    sat_t r;
    if (s[VAL_W] == s[VAL_W-1]) begin
      r.ovf = 1'b0;
      r.val = s[VAL_W-1:0];
    end else begin
      r.ovf = 1'b1;
      r.val = s[VAL_W] ? VAL_MIN : VAL_MAX;
    end
    return r;
  endfunction

  function automatic sat_t add_sat(input val_t a, input val_t b);
    logic signed [VAL_W:0] s;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    return from65(s);
  endfunction

  function automatic sat_t sub_sat(input val_t a, input val_t b);
    logic signed [VAL_W:0] s;
    s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
    return from65(s);
  endfunction

endpackage

### rtl/pti_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel that carries the segment count of one item.
// ----------------------------------------------------------------------------
interface pti_in_if;
  import pti_pkg::*;

  logic             valid;
  logic             ready;
  logic [SEG_W-1:0] segments;

  modport source (output valid, output segments, input ready);
  modport sink   (input valid, input segments, output ready);
endinterface

### rtl/pti_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries the areas, the error and the flag.
// ----------------------------------------------------------------------------
interface pti_out_if;
  import pti_pkg::*;

  logic               valid;
  logic               ready;
  logic signed [VAL_W-1:0] estimated_area;
  logic signed [VAL_W-1:0] exact_area;
  logic signed [VAL_W-1:0] estimate_error;
  logic               overflow_flag;

  modport source (output valid, output estimated_area, output exact_area,
                  output estimate_error, output overflow_flag, input ready);
  modport sink   (input valid, input estimated_area, input exact_area,
                  input estimate_error, input overflow_flag, output ready);
endinterface

### rtl/pti_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integrator datapath
// Configuration registers, restoring divider, shared 33x33 multiplier with
// product accumulator, Horner register, trapezoid sum and result registers.
// ----------------------------------------------------------------------------
module pti_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pti_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pti_pkg::CFG_W-1:0]         cfg_wdata,
  input  pti_pkg::dp_cmd_t                  cmd,
  output pti_pkg::dp_sts_t                  sts,
  output logic signed [pti_pkg::VAL_W-1:0]  estimated_area,
  output logic signed [pti_pkg::VAL_W-1:0]  exact_area,
  output logic signed [pti_pkg::VAL_W-1:0]  estimate_error,
  output logic                              overflow_flag
);
  import pti_pkg::*;

  // Configuration
  logic [DEG_W-1:0]         deg_r;
  logic signed [COEF_W-1:0] coef_r [0:MAX_DEGREE];
  logic signed [COEF_W-1:0] start_r;
  logic signed [COEF_W-1:0] end_r;

  // Working registers
  logic signed [Q_W-1:0]    ac_r   [1:MAX_DEGREE+1];
  logic signed [Q_W-1:0]    ac_nxt [1:MAX_DEGREE+1];
  logic signed [Q_W-1:0]    h_r, h_nxt;
  logic signed [HACC_W-1:0] hacc_r, hacc_nxt;
  logic signed [COEF_W-1:0] x_r, x_nxt;
  logic [DIV_W-1:0]         div_q_r, div_q_nxt;
  logic [SEG_W-2:0]         div_rem_r, div_rem_nxt;
  logic [SEG_W-1:0]         div_d_r, div_d_nxt;
  logic                     div_neg_r, div_neg_nxt;
  logic signed [PP_W-1:0]   prod_r, prod_nxt;
  logic [1:0]               pshift_r, pshift_nxt;
  logic                     pclr_r, pclr_nxt;
  logic                     pval_r, pval_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  val_t                     horn_r, horn_nxt;
  val_t                     sum_r, sum_nxt;
  val_t                     fb_r, fb_nxt;
  val_t                     area_r, area_nxt;
  val_t                     exact_r, exact_nxt;
  val_t                     err_r, err_nxt;
  logic                     sat_r, sat_nxt;
  val_t                     oarea_r, oarea_nxt;
  val_t                     oexact_r, oexact_nxt;
  val_t                     oerr_r, oerr_nxt;
  logic                     oovf_r, oovf_nxt;

  // Combinational helpers
  val_t                     coef_sel;
  logic signed [COEF_W:0]   diff;
  logic signed [Q_W-1:0]    dvd;
  logic signed [Q_W-1:0]    dvd_mag;
  logic [SEG_W-1:0]         trial;
  logic [SEG_W-1:0]         trial_dif;
  logic signed [Q_W-1:0]    quot;
  logic signed [HACC_W-1:0] hacc_step;
  val_t                     a_src;
  logic signed [OP_W-1:0]   mul_a, mul_b;
  logic signed [ACC_W-1:0]  pp_ext, pp_sh;
  sat_t                     fin16_s, fin_s, area_s, dbl_s, sum1_s, sum2_s, exact_s, err_s;

  assign sts.deg = (deg_r > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : deg_r;

  // Horner coefficient: polynomial terms widened to Q32.32, or the
  // antiderivative terms with a zero constant term.
  always_comb begin
    if (cmd.anti) begin
      if (cmd.k == '0) begin
        coef_sel = '0;
      end else begin
        coef_sel = {{(VAL_W-Q_W){ac_r[cmd.k][Q_W-1]}}, ac_r[cmd.k]};
      end
    end else begin
      coef_sel = {{(VAL_W-COEF_W-16){coef_r[cmd.k][COEF_W-1]}}, coef_r[cmd.k], 16'b0};
    end
  end

  // Divider operands.
  assign diff = {end_r[COEF_W-1], end_r} - {start_r[COEF_W-1], start_r};
  always_comb begin
    if (cmd.div_h) begin
      dvd = {diff, 16'b0};
    end else begin
      dvd = {{(Q_W-COEF_W-16){coef_r[cmd.k][COEF_W-1]}}, coef_r[cmd.k], 16'b0};
    end
  end
  assign dvd_mag   = dvd[Q_W-1] ? -dvd : dvd;
  assign trial     = {div_rem_r, div_q_r[DIV_W-1]};
  assign trial_dif = trial - div_d_r;
  assign quot      = div_neg_r ? -$signed({1'b0, div_q_r}) : $signed({1'b0, div_q_r});

  assign hacc_step = hacc_r + {{(HACC_W-Q_W){h_r[Q_W-1]}}, h_r};

  // Multiplier operand selection: 32-bit chunks of the 64-bit operand.
  assign a_src = cmd.mul_area ? sum_r : horn_r;
  always_comb begin
    mul_a = cmd.a_hi ? {a_src[VAL_W-1], a_src[VAL_W-1:32]} : {1'b0, a_src[31:0]};
    if (cmd.mul_area) begin
      mul_b = cmd.b_hi ? {{(OP_W-(Q_W-32)){h_r[Q_W-1]}}, h_r[Q_W-1:32]}
                       : {1'b0, h_r[31:0]};
    end else begin
      mul_b = {x_r[COEF_W-1], x_r};
    end
  end

  assign pp_ext = {{(ACC_W-PP_W){prod_r[PP_W-1]}}, prod_r};
  always_comb begin
    case (pshift_r)
      2'd0:    pp_sh = pp_ext;
      2'd1:    pp_sh = pp_ext <<< 32;
      default: pp_sh = pp_ext <<< 64;
    endcase
  end

  assign fin16_s = narrow_sat(acc_r >>> 16);
  assign fin_s   = add_sat(fin16_s.val, coef_sel);
  assign area_s  = narrow_sat(acc_r >>> 33);
  assign dbl_s   = add_sat(horn_r, horn_r);
  assign sum1_s  = add_sat(sum_r, horn_r);
  assign sum2_s  = add_sat(sum_r, dbl_s.val);
  assign exact_s = sub_sat(fb_r, horn_r);
  assign err_s   = sub_sat(area_r, exact_r);

  always_comb begin
    ac_nxt      = ac_r;
    h_nxt       = h_r;
    hacc_nxt    = hacc_r;
    x_nxt       = x_r;
    div_q_nxt   = div_q_r;
    div_rem_nxt = div_rem_r;
    div_d_nxt   = div_d_r;
    div_neg_nxt = div_neg_r;
    prod_nxt    = prod_r;
    pshift_nxt  = pshift_r;
    pclr_nxt    = pclr_r;
    pval_nxt    = 1'b0;
    acc_nxt     = acc_r;
    horn_nxt    = horn_r;
    sum_nxt     = sum_r;
    fb_nxt      = fb_r;
    area_nxt    = area_r;
    exact_nxt   = exact_r;
    err_nxt     = err_r;
    sat_nxt     = sat_r;
    oarea_nxt   = oarea_r;
    oexact_nxt  = oexact_r;
    oerr_nxt    = oerr_r;
    oovf_nxt    = oovf_r;

    // The accumulate stage adds the registered product in the cycle after the multiplier forms it.
    if (pval_r) begin
      acc_nxt = (pclr_r ? '0 : acc_r) + pp_sh;
    end

    case (cmd.op)
      OP_START: begin
        sat_nxt  = 1'b0;
        sum_nxt  = '0;
        hacc_nxt = '0;
      end
      OP_DIV_LOAD: begin
        div_q_nxt   = dvd_mag[DIV_W-1:0];
        div_rem_nxt = '0;
        div_d_nxt   = cmd.divisor;
        div_neg_nxt = dvd[Q_W-1];
      end
      OP_DIV_STEP: begin
        if (trial >= div_d_r) begin
          div_rem_nxt = trial_dif[SEG_W-2:0];
          div_q_nxt   = {div_q_r[DIV_W-2:0], 1'b1};
        end else begin
          div_rem_nxt = trial[SEG_W-2:0];
          div_q_nxt   = {div_q_r[DIV_W-2:0], 1'b0};
        end
      end
      OP_SAVE_H:  h_nxt = quot;
      OP_SAVE_AC: ac_nxt[cmd.k + K_W'(1)] = quot;
      OP_PT_LOAD: begin
        case (cmd.pt)
          PT_START: x_nxt = start_r;
          PT_END:   x_nxt = end_r;
          default: begin
            hacc_nxt = hacc_step;
            x_nxt    = start_r + hacc_step[COEF_W+15:16];
          end
        endcase
      end
      OP_HORN_INIT: horn_nxt = coef_sel;
      OP_MUL: begin
        prod_nxt   = mul_a * mul_b;
        pshift_nxt = {1'b0, cmd.a_hi} + {1'b0, cmd.b_hi};
        pclr_nxt   = cmd.mul_clr;
        pval_nxt   = 1'b1;
      end
      OP_HORN_FIN: begin
        horn_nxt = fin_s.val;
        sat_nxt  = sat_r | fin16_s.ovf | fin_s.ovf;
      end
      OP_SUM_F: begin
        sum_nxt = sum1_s.val;
        sat_nxt = sat_r | sum1_s.ovf;
      end
      OP_SUM_2F: begin
        sum_nxt = sum2_s.val;
        sat_nxt = sat_r | dbl_s.ovf | sum2_s.ovf;
      end
      OP_AREA: begin
        area_nxt = area_s.val;
        sat_nxt  = sat_r | area_s.ovf;
      end
      OP_FB_SAVE: fb_nxt = horn_r;
      OP_EXACT: begin
        exact_nxt = exact_s.val;
        sat_nxt   = sat_r | exact_s.ovf;
      end
      OP_ERR: begin
        err_nxt = err_s.val;
        sat_nxt = sat_r | err_s.ovf;
      end
      OP_PUBLISH: begin
        oarea_nxt  = area_r;
        oexact_nxt = exact_r;
        oerr_nxt   = err_r;
        oovf_nxt   = sat_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r   <= '0;
      start_r <= '0;
      end_r   <= RANGE_END_RST;
      for (int j = 0; j <= MAX_DEGREE; j++) begin
        coef_r[j] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_DEGREE) begin
        deg_r <= cfg_wdata[DEG_W-1:0];
      end else if (cfg_index == REG_START) begin
        start_r <= cfg_wdata;
      end else if (cfg_index == REG_END) begin
        end_r <= cfg_wdata;
      end else begin
        coef_r[K_W'(cfg_index - REG_COEF0)] <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pval_r <= 1'b0;
    end else begin
      pval_r <= pval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ac_r      <= ac_nxt;
    h_r       <= h_nxt;
    hacc_r    <= hacc_nxt;
    x_r       <= x_nxt;
    div_q_r   <= div_q_nxt;
    div_rem_r <= div_rem_nxt;
    div_d_r   <= div_d_nxt;
    div_neg_r <= div_neg_nxt;
    prod_r    <= prod_nxt;
    pshift_r  <= pshift_nxt;
    pclr_r    <= pclr_nxt;
    acc_r     <= acc_nxt;
    horn_r    <= horn_nxt;
    sum_r     <= sum_nxt;
    fb_r      <= fb_nxt;
    area_r    <= area_nxt;
    exact_r   <= exact_nxt;
    err_r     <= err_nxt;
    sat_r     <= sat_nxt;
    oarea_r   <= oarea_nxt;
    oexact_r  <= oexact_nxt;
    oerr_r    <= oerr_nxt;
    oovf_r    <= oovf_nxt;
  end

  assign estimated_area = oarea_r;
  assign exact_area     = oexact_r;
  assign estimate_error = oerr_r;
  assign overflow_flag  = oovf_r;

endmodule

### rtl/pti_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integrator controller
// Sequences divisions, Horner evaluations, the sum, the final scaling and
// the result handshake by issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
module pti_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [pti_pkg::SEG_W-1:0]    in_segments,
  output logic                         in_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output pti_pkg::dp_cmd_t             cmd,
  input  pti_pkg::dp_sts_t             sts
);
  import pti_pkg::*;

  state_t           state_r, state_nxt;
  ph_t              ph_r, ph_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SEG_W-1:0] seg_r, seg_nxt;
  logic [SEG_W-1:0] i_r, i_nxt;
  logic             div_h_r, div_h_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             anti;
  logic [K_W-1:0]   top_k;
  logic [SEG_W-1:0] seg_clamp;
  logic             accept;
  logic             publish;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign publish   = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign anti      = (ph_r == PH_ANTI_B) || (ph_r == PH_ANTI_A);
  assign top_k     = anti ? K_W'(sts.deg) + K_W'(1) : K_W'(sts.deg);

  always_comb begin
    if (in_segments == '0) begin
      seg_clamp = SEG_W'(1);
    end else if (in_segments > SEG_W'(MAX_SEGMENTS)) begin
      seg_clamp = SEG_W'(MAX_SEGMENTS);
    end else begin
      seg_clamp = in_segments;
    end
  end

  // Next state and counters.
  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    seg_nxt   = seg_r;
    i_nxt     = i_r;
    div_h_nxt = div_h_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          seg_nxt   = seg_clamp;
          div_h_nxt = 1'b1;
          k_nxt     = '0;
          state_nxt = S_DIV_LOAD;
        end
      end
      S_DIV_LOAD: begin
        cnt_nxt   = '0;
        state_nxt = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          state_nxt = S_DIV_SAVE;
        end
      end
      S_DIV_SAVE: begin
        if (div_h_r) begin
          div_h_nxt = 1'b0;
          k_nxt     = '0;
          state_nxt = S_DIV_LOAD;
        end else if (k_r == K_W'(sts.deg)) begin
          ph_nxt    = PH_FA;
          state_nxt = S_PT_LOAD;
        end else begin
          k_nxt     = k_r + K_W'(1);
          state_nxt = S_DIV_LOAD;
        end
      end
      S_PT_LOAD: state_nxt = S_H_INIT;
      S_H_INIT: begin
        if (top_k == '0) begin
          state_nxt = S_H_DONE;
        end else begin
          k_nxt     = top_k - K_W'(1);
          state_nxt = S_H_MUL0;
        end
      end
      S_H_MUL0: state_nxt = S_H_MUL1;
      S_H_MUL1: state_nxt = S_H_WAIT;
      S_H_WAIT: state_nxt = S_H_FIN;
      S_H_FIN: begin
        if (k_r == '0) begin
          state_nxt = S_H_DONE;
        end else begin
          k_nxt     = k_r - K_W'(1);
          state_nxt = S_H_MUL0;
        end
      end
      S_H_DONE: begin
        case (ph_r)
          PH_FA: begin
            ph_nxt    = PH_FB;
            state_nxt = S_PT_LOAD;
          end
          PH_FB: begin
            if (seg_r == SEG_W'(1)) begin
              cnt_nxt   = '0;
              state_nxt = S_A_MUL;
            end else begin
              i_nxt     = SEG_W'(1);
              ph_nxt    = PH_INT;
              state_nxt = S_PT_LOAD;
            end
          end
          PH_INT: begin
            if (i_r == seg_r - SEG_W'(1)) begin
              cnt_nxt   = '0;
              state_nxt = S_A_MUL;
            end else begin
              i_nxt     = i_r + SEG_W'(1);
              state_nxt = S_PT_LOAD;
            end
          end
          PH_ANTI_B: begin
            ph_nxt    = PH_ANTI_A;
            state_nxt = S_PT_LOAD;
          end
          PH_ANTI_A: state_nxt = S_ERR;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_A_MUL: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r[1:0] == 2'd3) begin
          state_nxt = S_A_WAIT;
        end
      end
      S_A_WAIT: state_nxt = S_AREA;
      S_AREA: begin
        ph_nxt    = PH_ANTI_B;
        state_nxt = S_PT_LOAD;
      end
      S_ERR: state_nxt = S_DONE;
      S_DONE: begin
        if (publish) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Datapath commands.
  always_comb begin
    cmd    = '0;
    cmd.op = OP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.op = OP_START;
        end
      end
      S_DIV_LOAD: begin
        cmd.op      = OP_DIV_LOAD;
        cmd.div_h   = div_h_r;
        cmd.k       = k_r;
        cmd.divisor = div_h_r ? seg_r : SEG_W'(k_r) + SEG_W'(1);
      end
      S_DIV_STEP: cmd.op = OP_DIV_STEP;
      S_DIV_SAVE: begin
        cmd.op = div_h_r ? OP_SAVE_H : OP_SAVE_AC;
        cmd.k  = k_r;
      end
      S_PT_LOAD: begin
        cmd.op = OP_PT_LOAD;
        case (ph_r)
          PH_FA, PH_ANTI_A: cmd.pt = PT_START;
          PH_FB, PH_ANTI_B: cmd.pt = PT_END;
          default:          cmd.pt = PT_NEXT;
        endcase
      end
      S_H_INIT: begin
        cmd.op   = OP_HORN_INIT;
        cmd.k    = top_k;
        cmd.anti = anti;
      end
      S_H_MUL0: begin
        cmd.op      = OP_MUL;
        cmd.mul_clr = 1'b1;
      end
      S_H_MUL1: begin
        cmd.op   = OP_MUL;
        cmd.a_hi = 1'b1;
      end
      S_H_WAIT: cmd.op = OP_NOP;
      S_H_FIN: begin
        cmd.op   = OP_HORN_FIN;
        cmd.k    = k_r;
        cmd.anti = anti;
      end
      S_H_DONE: begin
        case (ph_r)
          PH_FA, PH_FB: cmd.op = OP_SUM_F;
          PH_INT:       cmd.op = OP_SUM_2F;
          PH_ANTI_B:    cmd.op = OP_FB_SAVE;
          PH_ANTI_A:    cmd.op = OP_EXACT;
          default:      cmd.op = OP_NOP;
        endcase
      end
      S_A_MUL: begin
        cmd.op       = OP_MUL;
        cmd.mul_area = 1'b1;
        cmd.a_hi     = cnt_r[1];
        cmd.b_hi     = cnt_r[0];
        cmd.mul_clr  = (cnt_r[1:0] == 2'd0);
      end
      S_A_WAIT: cmd.op = OP_NOP;
      S_AREA:   cmd.op = OP_AREA;
      S_ERR:    cmd.op = OP_ERR;
      S_DONE: begin
        if (publish) begin
          cmd.op = OP_PUBLISH;
        end
      end
      default: cmd.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= PH_FA;
      k_r         <= '0;
      cnt_r       <= '0;
      seg_r       <= SEG_W'(1);
      i_r         <= '0;
      div_h_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      k_r         <= k_nxt;
      cnt_r       <= cnt_nxt;
      seg_r       <= seg_nxt;
      i_r         <= i_nxt;
      div_h_r     <= div_h_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A new result is only loaded when the previous one is gone or leaving.
  a_publish_safe: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_PUBLISH) |-> (!out_valid_r || out_ready))
    else $error("result overwritten while still held");

  // An accepted item always starts with the step division.
  a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_DIV_LOAD) && div_h_r)
    else $error("accepted item did not start the step division");

  // Interior sample index stays within 1 .. segments - 1.
  a_int_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PT_LOAD && ph_r == PH_INT) |-> (i_r != '0) && (i_r < seg_r))
    else $error("interior sample index out of range");

  // Horner coefficient index never passes the maximum degree.
  a_horner_k: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_H_FIN) |-> (k_r <= K_W'(MAX_DEGREE)))
    else $error("Horner coefficient index out of range");

endmodule

### rtl/polynomial_trapezoid_integrator.sv
`timescale 1ns / 1ps
// One item is worked at a time; the next item is accepted once the result is in
// the output register, so no new item is taken before the last one is finished.
// The run time is set by the shared 33x33 multiplier (two partial products per Horner
// step) and the one-bit-per-cycle divider. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
// Polynomial trapezoid integrator
// Trapezoid estimate, exact antiderivative area and error of a configured
// polynomial over a configured range, one result per segment-count item.
// ----------------------------------------------------------------------------
module polynomial_trapezoid_integrator (
  input  logic                          clk,
  input  logic                          rst_n,
  pti_in_if.sink                        in_ch,
  pti_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [pti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pti_pkg::CFG_W-1:0]     cfg_wdata
);
  import pti_pkg::*;

  // The controller and the datapath talk only through one command word per
  // cycle and a small status word (the clamped degree).
  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller owns the handshakes. It accepts an item only when idle,
  // then runs the step division and one division per antiderivative term,
  // the Horner evaluations at both ends and at every interior sample, the
  // final scaling multiply, and the two antiderivative evaluations. The
  // result is copied into the output register only once the previous result
  // has been taken, so the output holds steady while stalled.
  pti_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_segments (in_ch.segments),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .cmd         (cmd),
    .sts         (sts)
  );

  // The datapath holds the configuration registers and all arithmetic. All
  // intermediate saturations are collected into one sticky flag per item.
  pti_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .sts            (sts),
    .estimated_area (out_ch.estimated_area),
    .exact_area     (out_ch.exact_area),
    .estimate_error (out_ch.estimate_error),
    .overflow_flag  (out_ch.overflow_flag)
  );

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polynomial trapezoid integrator testbench
// Loads the polynomial, the degree and the limits, then feeds segment counts
// through the input channel with bursty timing while the result channel
// stalls on its own pattern. A fixed-point model in the scoreboard predicts
// each result, and every delivered result is compared with the oldest one.
// ----------------------------------------------------------------------------
module tb_top;
  import pti_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    val_t est;
    val_t exact;
    val_t err;
    logic ovf;
  } area_t;

  // Scoreboard: keeps its own copy of the registers, computes the expected
  // areas for every accepted item and checks results in order.
  class area_scoreboard;
    logic [DEG_W-1:0]         degree;
    logic signed [COEF_W-1:0] coef[MAX_DEGREE+1];
    logic signed [COEF_W-1:0] lim_lo;
    logic signed [COEF_W-1:0] lim_hi;
    area_t                    pending_areas[$];
    int                       errors;
    bit                       clipped;

    function new();
      degree = '0;
      foreach (coef[k]) coef[k] = '0;
      lim_lo = '0;
      lim_hi = RANGE_END_RST;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_DEGREE) degree = data[DEG_W-1:0];
      else if (idx == REG_START) lim_lo = data;
      else if (idx == REG_END) lim_hi = data;
      else coef[idx - REG_COEF0] = data;
    endfunction

    // Saturate a wide value to 64 bits and remember that it happened.
    function val_t clip(wide_t w);
      if (w[127:63] != {65{w[63]}}) begin
        clipped = 1'b1;
        return w[127] ? VAL_MIN : VAL_MAX;
      end
      return w[63:0];
    endfunction

    function val_t mul_shift(val_t a, val_t b, int k);
      wide_t p;
      p = wide_t'(a) * wide_t'(b);
      return clip(p >>> k);
    endfunction

    function val_t plus(val_t a, val_t b);
      return clip(wide_t'(a) + wide_t'(b));
    endfunction

    function val_t minus(val_t a, val_t b);
      return clip(wide_t'(a) - wide_t'(b));
    endfunction

    function val_t horner(val_t c[MAX_DEGREE+2], int deg, val_t x);
      val_t acc;
      acc = c[deg];
      for (int k = deg - 1; k >= 0; k--) begin
        acc = mul_shift(acc, x, 16);
        acc = plus(acc, c[k]);
      end
      return acc;
    endfunction

    function void note_item(logic [SEG_W-1:0] seg);
      val_t  fc[MAX_DEGREE+2];
      val_t  ac[MAX_DEGREE+2];
      val_t  a, b, h, sum, v, x;
      int    deg, n;
      area_t r;
      clipped = 1'b0;
      deg = (degree > MAX_DEGREE) ? MAX_DEGREE : int'(degree);
      n = (seg == 0) ? 1 : ((seg > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(seg));
      foreach (fc[k]) begin
        fc[k] = '0;
        ac[k] = '0;
      end
      for (int k = 0; k <= deg; k++) begin
        fc[k] = val_t'(coef[k]) <<< 16;
        ac[k+1] = fc[k] / val_t'(k + 1);
      end
      a = val_t'(lim_lo);
      b = val_t'(lim_hi);
      h = ((b - a) <<< 16) / val_t'(n);
      sum = plus(horner(fc, deg, a), horner(fc, deg, b));
      for (int i = 1; i < n; i++) begin
        x = a + ((h * val_t'(i)) >>> 16);
        v = horner(fc, deg, x);
        sum = plus(sum, plus(v, v));
      end
      r.est = mul_shift(sum, h, 33);
      r.exact = minus(horner(ac, deg + 1, b), horner(ac, deg + 1, a));
      r.err = minus(r.est, r.exact);
      r.ovf = clipped;
      pending_areas.push_back(r);
    endfunction

    function void check_result(val_t est, val_t exact, val_t err, logic ovf);
      area_t e;
      if (pending_areas.size() == 0) begin
        $display("%0t: unexpected result est=%h", $time, est);
        errors++;
        return;
      end
      e = pending_areas.pop_front();
      if (est !== e.est) begin
        $display("%0t: estimated_area expected %h actual %h", $time, e.est, est);
        errors++;
      end
      if (exact !== e.exact) begin
        $display("%0t: exact_area expected %h actual %h", $time, e.exact, exact);
        errors++;
      end
      if (err !== e.err) begin
        $display("%0t: estimate_error expected %h actual %h", $time, e.err, err);
        errors++;
      end
      if (ovf !== e.ovf) begin
        $display("%0t: overflow_flag expected %b actual %b", $time, e.ovf, ovf);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  pti_in_if  in_if ();
  pti_out_if out_if ();

  polynomial_trapezoid_integrator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  area_scoreboard sb = new();

  // The limit leaves room for the receiver's stalls and the sender's gaps on
  // top of the time that a correct item takes.
  localparam int IDLE_LIMIT = 40000;

  int burst_left;
  int idle_cycles;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.segments = '0;
    out_if.ready = 1'b0;
  end

  // Result side: check every accepted result, then pick the next ready value.
  // The receiver alternates between stretches with no stalls and stretches
  // with random stalls.
  int stall_mode;
  int stretch_left;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        sb.check_result(out_if.estimated_area, out_if.exact_area,
                        out_if.estimate_error, out_if.overflow_flag);
      end
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(20, 400);
        stall_mode = $urandom_range(0, 2);
      end else begin
        stretch_left--;
      end
      case (stall_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        default: out_if.ready <= ($urandom_range(0, 9) > 6);
      endcase
    end
  end

  // Watchdog: a long stretch with nothing accepted on either side means a hang.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // Loads all eight registers in one pass and then drops the write enable.
  task automatic load_config(logic [DEG_W-1:0] deg, logic [CFG_W-1:0] c0,
                             logic [CFG_W-1:0] c1, logic [CFG_W-1:0] c2,
                             logic [CFG_W-1:0] c3, logic [CFG_W-1:0] c4,
                             logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi);
    write_reg(REG_DEGREE, CFG_W'(deg));
    write_reg(REG_COEF0, c0);
    write_reg(REG_COEF0 + 3'd1, c1);
    write_reg(REG_COEF0 + 3'd2, c2);
    write_reg(REG_COEF0 + 3'd3, c3);
    write_reg(REG_COEF0 + 3'd4, c4);
    write_reg(REG_START, lo);
    write_reg(REG_END, hi);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Sends one item. The valid line stays high across a burst and only drops
  // when a gap follows, so it is never lowered and raised in the same step.
  task automatic send_segments(logic [SEG_W-1:0] seg);
    int gap;
    in_if.valid <= 1'b1;
    in_if.segments <= seg;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_item(seg);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Waits until every predicted result has come back, with valid low, so the
  // block is idle before the registers change.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_areas.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Mostly small counts to keep the run short, now and then any 8-bit value or zero.
  function automatic logic [SEG_W-1:0] pick_segments();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return SEG_W'($urandom_range(1, 12));
    if (r < 95) return SEG_W'($urandom_range(0, 255));
    return '0;
  endfunction

  // Small values keep the polynomial in range so the sums are meaningful;
  // full-width values exercise saturation.
  function automatic logic [CFG_W-1:0] pick_value(bit full, int shift);
    logic signed [CFG_W-1:0] v;
    v = $urandom;
    return full ? v : (v >>> shift);
  endfunction

  initial begin
    logic [SEG_W-1:0] directed [9];
    bit full;
    directed = '{8'd0, 8'd1, 8'd2, 8'd127, 8'd128, 8'd129, 8'd255, 8'd85, 8'd170};
    burst_left = 1;
    idle_cycles = 0;
    stretch_left = 0;
    stall_mode = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: f(x) = 0 over [0, 1], every segment count corner.
    foreach (directed[i]) send_segments(directed[i]);
    drain();

    // Quadratic over [0, 1] where the trapezoid error is visible.
    load_config(3'd2, 32'h0001_0000, 32'hFFFE_0000, 32'h0003_0000, 32'd0, 32'd0,
                32'd0, 32'h0001_0000);
    send_segments(8'd1);
    send_segments(8'd4);
    send_segments(8'd128);
    drain();

    // Degree beyond the maximum, largest coefficients, widest range:
    // saturation everywhere.
    load_config(3'd7, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_segments(8'd1);
    send_segments(8'd3);
    send_segments(8'd200);
    drain();

    // Reversed limits give a negative step.
    load_config(3'd4, 32'h0000_8000, 32'hFFFF_0000, 32'h0000_4000, 32'h0000_2000,
                32'hFFFF_F000, 32'h0003_0000, 32'hFFFD_0000);
    send_segments(8'd2);
    send_segments(8'd7);
    send_segments(8'd64);
    drain();

    // Random phases, each under its own register settings.
    for (int phase = 0; phase < 12; phase++) begin
      full = (phase % 4 == 3);
      load_config(DEG_W'($urandom_range(0, 7)), pick_value(full, 12),
                  pick_value(full, 12), pick_value(full, 14), pick_value(full, 16),
                  pick_value(full, 18), pick_value(full, 11), pick_value(full, 11));
      repeat (68) send_segments(pick_segments());
      drain();
    end

    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending_areas.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/pti_pkg.sv
rtl/pti_in_if.sv
rtl/pti_out_if.sv
rtl/pti_dp.sv
rtl/pti_ctrl.sv
rtl/polynomial_trapezoid_integrator.sv
verif/tb_top.sv
